// ===== rtl/p2i_pkg.sv =====
// Shared types and constants for the planar to interleaved colour converter.
// Used by the front, queue, back and top-level modules; depends on nothing.

package p2i_pkg;

   // Configuration register map (index = byte address / 4)
   typedef enum logic [2:0] {
      REG_PIXELS_PER_LINE = 3'd0,
      REG_LINES_PER_IMAGE = 3'd1,
      REG_CHANNEL_COUNT   = 3'd2,
      REG_SAMPLE_BITS     = 3'd3,
      REG_COLOR_MODE      = 3'd4
   } reg_index_type;

   // Colour modes for three-channel images
   localparam logic [1:0] MODE_COPY  = 2'd0;
   localparam logic [1:0] MODE_CIELAB = 2'd1;
   localparam logic [1:0] MODE_YCC   = 2'd2;

   // How the back end must treat one queued item
   typedef enum logic [2:0] {
      KIND_PASS,
      KIND_COPY,
      KIND_LAB,
      KIND_YCC,
      KIND_CMYK
   } kind_type;

   // Configuration as seen by the front end
   typedef struct packed {
      logic [13:0] pixels_per_line;
      logic [15:0] lines_per_image;
      logic [2:0]  channel_count;
      logic [3:0]  sample_bits;
      logic [1:0]  color_mode;
   } cfg_type;

   // One queued item: stored plane bytes, the incoming byte and its markers
   typedef struct packed {
      logic [7:0] a0;
      logic [7:0] a1;
      logic [7:0] a2;
      logic [7:0] b;
      kind_type   kind;
      logic       eol;
      logic       eoi;
   } entry_type;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // YCbCr to RGB fixed point
   localparam int FRAC_BITS = 10;
   localparam int PROD_W    = 21;
   localparam int SUM_W     = 22;
   localparam logic signed [11:0] K_CR_R = 12'sd1435;
   localparam logic signed [11:0] K_CB_G = -12'sd352;
   localparam logic signed [11:0] K_CR_G = -12'sd731;
   localparam logic signed [11:0] K_CB_B = 12'sd1814;
   localparam logic [7:0]         CHROMA_FLIP = 8'h80;
   localparam logic signed [8:0]  CHROMA_BIAS = 9'sd128;

endpackage

// ===== rtl/p2i_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module p2i_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/p2i_front.sv =====
// Front end: takes input items, tracks plane/pixel/line position, fills the
// line store and queues items that release a result. Uses p2i_pkg, p2i_ram.

module p2i_front #(
   parameter int MAX_WIDTH = 8192
) (
   input  logic                          clock,
   input  logic                          reset,
   input  p2i_pkg::cfg_type              cfg,
   input  logic                          restart,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,
   input  logic [p2i_pkg::QCNT_W-1:0]    queue_count,
   output logic                          push,
   output p2i_pkg::entry_type            push_entry
);

   localparam int PIX_W = $clog2(MAX_WIDTH);
   localparam int LEN_W = PIX_W + 1;

   logic [PIX_W-1:0]  pixel_ff, pixel_in;
   logic [1:0]        plane_ff, plane_in;
   logic [15:0]       line_ff, line_in;

   logic              s1_valid_ff, s1_valid_in;
   logic [7:0]        s1_byte_ff;
   p2i_pkg::kind_type s1_kind_ff;
   logic              s1_eol_ff;
   logic              s1_eoi_ff;

   logic              accept;
   logic              interleave;
   logic [13:0]       width_nz;
   logic [LEN_W-1:0]  width_eff;
   logic [3:0]        bits_eff;
   logic [LEN_W+3:0]  pass_bits;
   logic [LEN_W-1:0]  pass_len;
   logic [LEN_W-1:0]  line_len;
   logic [15:0]       lines_eff;
   logic [1:0]        plane_last;
   logic              last_pixel;
   logic              last_plane;
   logic              last_line;
   logic              store_byte;
   p2i_pkg::kind_type kind;
   logic [2:0]        wr_en;
   logic [7:0]        rd_q [3];

   // Effective line geometry
   always_comb begin
      width_nz = (cfg.pixels_per_line == '0) ? 14'd1 : cfg.pixels_per_line;
      if (32'(width_nz) > 32'(MAX_WIDTH)) begin
         width_eff = LEN_W'(MAX_WIDTH);
      end else begin
         width_eff = LEN_W'(width_nz);
      end
      if (cfg.sample_bits == '0) begin
         bits_eff = 4'd1;
      end else if (cfg.sample_bits > 4'd8) begin
         bits_eff = 4'd8;
      end else begin
         bits_eff = cfg.sample_bits;
      end
      pass_bits = (LEN_W + 4)'(width_eff) * (LEN_W + 4)'(bits_eff);
      pass_len  = LEN_W'(pass_bits >> 3);
      if (pass_len == '0) begin
         pass_len = LEN_W'(1);
      end
      interleave = (cfg.channel_count == 3'd3) || (cfg.channel_count == 3'd4);
      line_len   = interleave ? width_eff : pass_len;
      lines_eff  = (cfg.lines_per_image == '0) ? 16'd1 : cfg.lines_per_image;
      plane_last = !interleave ? 2'd0 : ((cfg.channel_count == 3'd4) ? 2'd3 : 2'd2);
   end

   // Position flags
   assign last_pixel = (LEN_W'(pixel_ff) + LEN_W'(1)) == line_len;
   assign last_plane = plane_ff == plane_last;
   assign last_line  = (17'(line_ff) + 17'd1) == 17'(lines_eff);
   assign store_byte = interleave && !last_plane;

   // Classify the item for the back end
   always_comb begin
      if (!interleave) begin
         kind = p2i_pkg::KIND_PASS;
      end else if (cfg.channel_count == 3'd4) begin
         kind = p2i_pkg::KIND_CMYK;
      end else if (cfg.color_mode == p2i_pkg::MODE_CIELAB) begin
         kind = p2i_pkg::KIND_LAB;
      end else if (cfg.color_mode == p2i_pkg::MODE_YCC) begin
         kind = p2i_pkg::KIND_YCC;
      end else begin
         kind = p2i_pkg::KIND_COPY;
      end
   end

   // Room for this item and the one in the read stage
   assign req_tready = (4'(queue_count) + 4'(s1_valid_ff)) < 4'(p2i_pkg::QUEUE_DEPTH);
   assign accept     = req_tvalid && req_tready;

   // Stream position counters
   always_comb begin
      pixel_in = pixel_ff;
      plane_in = plane_ff;
      line_in  = line_ff;
      priority if (restart) begin
         pixel_in = '0;
         plane_in = '0;
         line_in  = '0;
      end else if (accept) begin
         if (last_pixel) begin
            pixel_in = '0;
            if (last_plane) begin
               plane_in = '0;
               line_in  = last_line ? 16'd0 : line_ff + 16'd1;
            end else begin
               plane_in = plane_ff + 2'd1;
            end
         end else begin
            pixel_in = pixel_ff + PIX_W'(1);
         end
      end else begin
         // no item: position holds
      end
   end

   assign s1_valid_in = accept && !store_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_ff    <= '0;
         plane_ff    <= '0;
         line_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         pixel_ff    <= pixel_in;
         plane_ff    <= plane_in;
         line_ff     <= line_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Read stage payload, captured alongside the registered line store read
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req_tdata;
         s1_kind_ff <= kind;
         s1_eol_ff  <= last_plane && last_pixel;
         s1_eoi_ff  <= last_plane && last_pixel && last_line;
      end
   end

   // Line store: one RAM per held plane
   for (genvar p = 0; p < 3; p++) begin : g_plane
      assign wr_en[p] = accept && store_byte && (plane_ff == 2'(p));
      p2i_ram #(
         .WIDTH (8),
         .DEPTH (MAX_WIDTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[p]),
         .wr_addr (pixel_ff),
         .wr_data (req_tdata),
         .rd_en   (accept && interleave && last_plane),
         .rd_addr (pixel_ff),
         .rd_data (rd_q[p])
      );
   end

   // Hand the item to the queue
   assign push            = s1_valid_ff;
   assign push_entry.a0   = rd_q[0];
   assign push_entry.a1   = rd_q[1];
   assign push_entry.a2   = rd_q[2];
   assign push_entry.b    = s1_byte_ff;
   assign push_entry.kind = s1_kind_ff;
   assign push_entry.eol  = s1_eol_ff;
   assign push_entry.eoi  = s1_eoi_ff;

endmodule

// ===== rtl/p2i_queue.sv =====
// Short queue of classified items between the front and back ends.
// Uses p2i_pkg.

module p2i_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  p2i_pkg::entry_type         push_entry,
   input  logic                       pop,
   output logic                       pop_valid,
   output p2i_pkg::entry_type         pop_entry,
   output logic [p2i_pkg::QCNT_W-1:0] count
);

   p2i_pkg::entry_type                slot_ff [p2i_pkg::QUEUE_DEPTH];
   logic [p2i_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [p2i_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [p2i_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign do_push = push && (count_ff != p2i_pkg::QCNT_W'(p2i_pkg::QUEUE_DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + p2i_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + p2i_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + p2i_pkg::QCNT_W'(do_push) - p2i_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_valid = count_ff != '0;
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ===== rtl/p2i_back.sv =====
// Back end: colour conversion in two stages (products, then sums with
// clamping and sample selection) feeding the result register. Uses p2i_pkg.

module p2i_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  p2i_pkg::entry_type q_entry,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [39:0]        rsp_tdata,
   output logic               rsp_tlast,
   output logic               rsp_tuser
);

   // Product stage
   logic                                 p_valid_ff, p_valid_in;
   p2i_pkg::entry_type                   p_entry_ff;
   logic signed [p2i_pkg::PROD_W-1:0]    p_cr_r_ff, p_cb_g_ff, p_cr_g_ff, p_cb_b_ff;
   logic signed [8:0]                    cb;
   logic signed [8:0]                    cr;
   logic                                 p_ready;

   // Result register
   logic                                 o_valid_ff, o_valid_in;
   logic [7:0]                           o_s0_ff, o_s0_in;
   logic [7:0]                           o_s1_ff, o_s1_in;
   logic [7:0]                           o_s2_ff, o_s2_in;
   logic [7:0]                           o_s3_ff, o_s3_in;
   logic [2:0]                           o_cnt_ff, o_cnt_in;
   logic                                 o_eol_ff;
   logic                                 o_eoi_ff;

   logic signed [p2i_pkg::SUM_W-1:0]     y;
   logic signed [p2i_pkg::SUM_W-1:0]     sum_r, sum_g, sum_b;

   function automatic logic [7:0] clamp_byte(input logic signed [p2i_pkg::SUM_W-1:0] s);
      logic [7:0] res;
      if (s[p2i_pkg::SUM_W-1]) begin
         res = 8'd0;
      end else if (|s[p2i_pkg::SUM_W-2:p2i_pkg::FRAC_BITS+8]) begin
         res = 8'hFF;
      end else begin
         res = s[p2i_pkg::FRAC_BITS+7:p2i_pkg::FRAC_BITS];
      end
      return res;
   endfunction

   // Flow control: each stage moves when the one after it has room
   assign p_ready    = !o_valid_ff || rsp_tready;
   assign q_pop      = q_valid && (!p_valid_ff || p_ready);
   assign p_valid_in = (!p_valid_ff || p_ready) ? q_valid : p_valid_ff;
   assign o_valid_in = p_ready ? p_valid_ff : o_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   // Chroma offsets and products
   assign cb = $signed({1'b0, q_entry.a1}) - p2i_pkg::CHROMA_BIAS;
   assign cr = $signed({1'b0, q_entry.b}) - p2i_pkg::CHROMA_BIAS;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         p_entry_ff <= q_entry;
         p_cr_r_ff  <= p2i_pkg::PROD_W'(cr) * p2i_pkg::PROD_W'(p2i_pkg::K_CR_R);
         p_cb_g_ff  <= p2i_pkg::PROD_W'(cb) * p2i_pkg::PROD_W'(p2i_pkg::K_CB_G);
         p_cr_g_ff  <= p2i_pkg::PROD_W'(cr) * p2i_pkg::PROD_W'(p2i_pkg::K_CR_G);
         p_cb_b_ff  <= p2i_pkg::PROD_W'(cb) * p2i_pkg::PROD_W'(p2i_pkg::K_CB_B);
      end
   end

   // Sums in fixed point
   assign y = $signed({{(p2i_pkg::SUM_W - 8 - p2i_pkg::FRAC_BITS){1'b0}}, p_entry_ff.a0,
                       {p2i_pkg::FRAC_BITS{1'b0}}});
   assign sum_r = y + p2i_pkg::SUM_W'(p_cr_r_ff);
   assign sum_g = y + p2i_pkg::SUM_W'(p_cb_g_ff) + p2i_pkg::SUM_W'(p_cr_g_ff);
   assign sum_b = y + p2i_pkg::SUM_W'(p_cb_b_ff);

   // Sample selection per kind
   always_comb begin
      o_s0_in  = 8'd0;
      o_s1_in  = 8'd0;
      o_s2_in  = 8'd0;
      o_s3_in  = 8'd0;
      o_cnt_in = 3'd3;
      unique case (p_entry_ff.kind)
         p2i_pkg::KIND_PASS: begin
            o_s0_in  = p_entry_ff.b;
            o_cnt_in = 3'd1;
         end
         p2i_pkg::KIND_LAB: begin
            o_s0_in = p_entry_ff.a0;
            o_s1_in = p_entry_ff.a1 ^ p2i_pkg::CHROMA_FLIP;
            o_s2_in = p_entry_ff.b ^ p2i_pkg::CHROMA_FLIP;
         end
         p2i_pkg::KIND_YCC: begin
            o_s0_in = clamp_byte(sum_r);
            o_s1_in = clamp_byte(sum_g);
            o_s2_in = clamp_byte(sum_b);
         end
         p2i_pkg::KIND_CMYK: begin
            o_s0_in  = p_entry_ff.a0;
            o_s1_in  = p_entry_ff.a1;
            o_s2_in  = p_entry_ff.a2;
            o_s3_in  = p_entry_ff.b;
            o_cnt_in = 3'd4;
         end
         default: begin
            o_s0_in = p_entry_ff.a0;
            o_s1_in = p_entry_ff.a1;
            o_s2_in = p_entry_ff.b;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (p_ready && p_valid_ff) begin
         o_s0_ff  <= o_s0_in;
         o_s1_ff  <= o_s1_in;
         o_s2_ff  <= o_s2_in;
         o_s3_ff  <= o_s3_in;
         o_cnt_ff <= o_cnt_in;
         o_eol_ff <= p_entry_ff.eol;
         o_eoi_ff <= p_entry_ff.eoi;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = {5'd0, o_cnt_ff, o_s3_ff, o_s2_ff, o_s1_ff, o_s0_ff};
   assign rsp_tlast  = o_eol_ff;
   assign rsp_tuser  = o_eoi_ff;

endmodule

// ===== rtl/planar_to_interleaved_color_convert.sv =====
// Top level of the planar to interleaved colour converter: register port,
// front end with line store, item queue and conversion back end.
// Depends on p2i_pkg, p2i_front, p2i_queue, p2i_back (and p2i_ram below them).
//
// Usage: bytes of a scanline-planar image enter on req_* (one byte per item).
// With three or four channels the earlier planes of a line are held in the
// line store and each byte of the last plane releases one interleaved pixel
// on rsp_*; any other channel count passes every byte through as a one-sample
// result. rsp_tlast marks the last result of a line, rsp_tuser the last of
// the image. Registers must be written over the csr_* port only while the
// stream is idle; the block does not enforce this. Any write restarts the
// stream position at the first byte of an image. Throughput is one item per
// cycle while the receiver keeps up. A releasing byte goes through the line
// store read, the queue, the fixed-point products and the result register.
// At reset the position counters clear and the registers take their default
// values; the line store is not cleared and needs no clearing pass.
// When the receiver stalls, the result register, the product stage and a
// four-item queue fill up and req_tready drops; nothing is lost.

module planar_to_interleaved_color_convert #(
   parameter int MAX_WIDTH = 8192
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] sample_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_s0, [15:8] out_s1, [23:16] out_s2,
                                    // [31:24] out_s3, [34:32] sample_count, rest 0
   output logic        rsp_tlast,   // end_of_line
   output logic        rsp_tuser,   // [0] end_of_image
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   p2i_pkg::cfg_type                cfg_ff, cfg_in;
   logic                            cfg_write;
   p2i_pkg::reg_index_type          reg_index;
   logic                            push;
   p2i_pkg::entry_type              push_entry;
   logic                            q_pop;
   logic                            q_valid;
   p2i_pkg::entry_type              q_entry;
   logic [p2i_pkg::QCNT_W-1:0]      q_count;

   // Register port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = p2i_pkg::reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (reg_index)
            p2i_pkg::REG_PIXELS_PER_LINE: cfg_in.pixels_per_line = csr_pwdata[13:0];
            p2i_pkg::REG_LINES_PER_IMAGE: cfg_in.lines_per_image = csr_pwdata[15:0];
            p2i_pkg::REG_CHANNEL_COUNT:   cfg_in.channel_count   = csr_pwdata[2:0];
            p2i_pkg::REG_SAMPLE_BITS:     cfg_in.sample_bits     = csr_pwdata[3:0];
            p2i_pkg::REG_COLOR_MODE:      cfg_in.color_mode      = csr_pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixels_per_line <= 14'd1;
         cfg_ff.lines_per_image <= 16'd1;
         cfg_ff.channel_count   <= 3'd3;
         cfg_ff.sample_bits     <= 4'd8;
         cfg_ff.color_mode      <= p2i_pkg::MODE_COPY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register read-back
   always_comb begin
      unique case (reg_index)
         p2i_pkg::REG_PIXELS_PER_LINE: csr_prdata = 32'(cfg_ff.pixels_per_line);
         p2i_pkg::REG_LINES_PER_IMAGE: csr_prdata = 32'(cfg_ff.lines_per_image);
         p2i_pkg::REG_CHANNEL_COUNT:   csr_prdata = 32'(cfg_ff.channel_count);
         p2i_pkg::REG_SAMPLE_BITS:     csr_prdata = 32'(cfg_ff.sample_bits);
         p2i_pkg::REG_COLOR_MODE:      csr_prdata = 32'(cfg_ff.color_mode);
         default:                      csr_prdata = 32'd0;
      endcase
   end

   p2i_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .restart     (cfg_write),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .queue_count (q_count),
      .push        (push),
      .push_entry  (push_entry)
   );

   p2i_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry),
      .count      (q_count)
   );

   p2i_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== tb/sv/planar_to_interleaved_color_convert_test.sv =====
// Self-checking testbench for planar_to_interleaved_color_convert: drives
// planar image bytes and register writes, predicts every interleaved pixel.
// Depends on p2i_pkg and the RTL of the converter; reads no files.

module planar_to_interleaved_color_convert_test;

   localparam int LINE_MAX      = 8192;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int REPORT_LIMIT  = 40;

   // Register index that decodes to nothing; a write still restarts the stream
   localparam logic [2:0] REG_UNMAPPED = 3'd5;

   // YCbCr to RGB weights, 10 fractional bits
   localparam int FIXED_ONE     = 1024;
   localparam int CHROMA_MID    = 128;
   localparam int R_FROM_CR     = 1435;
   localparam int G_FROM_CB     = -352;
   localparam int G_FROM_CR     = -731;
   localparam int B_FROM_CB     = 1814;
   localparam logic [7:0] LAB_FLIP = 8'h80;

   typedef struct packed {
      logic [7:0] s0;
      logic [7:0] s1;
      logic [7:0] s2;
      logic [7:0] s3;
      logic [2:0] count;
      logic       eol;
      logic       eoi;
   } pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] sample_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // [7:0] s0, [15:8] s1, [23:16] s2, [31:24] s3,
                                    // [34:32] sample_count
   logic        rsp_tlast;          // end_of_line
   logic        rsp_tuser;          // [0] end_of_image
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = 5'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predictor copy of the registers and stream position
   logic [13:0] pixels_cfg;
   logic [15:0] lines_cfg;
   logic [2:0]  channels_cfg;
   logic [3:0]  sample_bits_cfg;
   logic [1:0]  colour_mode_cfg;
   int          plane_pos;
   int          pixel_pos;
   int          line_pos;
   logic [7:0]  line_store [0:3*LINE_MAX-1];

   pixel_type   expected_pixels [$];
   int          sender_idle_pct = 0;
   int          receiver_idle_pct = 0;
   int          fail_count = 0;
   int          pixels_checked = 0;
   int          bytes_sent = 0;
   int          writes_done = 0;
   int          cycle_count = 0;

   planar_to_interleaved_color_convert #(.MAX_WIDTH(LINE_MAX)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // Run-time guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached, %0d pixels still outstanding",
                  $time, expected_pixels.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Compare every accepted result with the oldest predicted pixel
   always @(posedge clock) begin : check_pixels
      pixel_type got;
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.s0    = rsp_tdata[7:0];
         got.s1    = rsp_tdata[15:8];
         got.s2    = rsp_tdata[23:16];
         got.s3    = rsp_tdata[31:24];
         got.count = rsp_tdata[34:32];
         got.eol   = rsp_tlast;
         got.eoi   = rsp_tuser;
         pixels_checked++;
         if (expected_pixels.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display({"%0t: unexpected pixel, expected none, ",
                         "got %h %h %h %h n=%0d eol=%b eoi=%b"},
                        $time, got.s0, got.s1, got.s2, got.s3, got.count, got.eol, got.eoi);
         end else begin
            want = expected_pixels.pop_front();
            if (got.s0 !== want.s0 || got.s1 !== want.s1 || got.s2 !== want.s2 ||
                got.s3 !== want.s3 || got.count !== want.count ||
                got.eol !== want.eol || got.eoi !== want.eoi) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display({"%0t: pixel mismatch, expected %h %h %h %h n=%0d eol=%b eoi=%b, ",
                            "got %h %h %h %h n=%0d eol=%b eoi=%b"},
                           $time, want.s0, want.s1, want.s2, want.s3, want.count, want.eol,
                           want.eoi, got.s0, got.s1, got.s2, got.s3, got.count, got.eol,
                           got.eoi);
            end
         end
      end
   end

   // ---------------------------------------------------------------- predictor

   task automatic predictor_reset();
      pixels_cfg      = 14'd1;
      lines_cfg       = 16'd1;
      channels_cfg    = 3'd3;
      sample_bits_cfg = 4'd8;
      colour_mode_cfg = p2i_pkg::MODE_COPY;
      plane_pos = 0;
      pixel_pos = 0;
      line_pos  = 0;
   endtask

   // Planes per line, bytes per plane and lines per image after saturation
   function automatic void line_geometry(output int planes, output int len, output int lines);
      int w;
      int bits;
      w = (pixels_cfg == 0) ? 1 : ((pixels_cfg > LINE_MAX) ? LINE_MAX : int'(pixels_cfg));
      lines = (lines_cfg == 0) ? 1 : int'(lines_cfg);
      if (channels_cfg == 3'd3 || channels_cfg == 3'd4) begin
         planes = channels_cfg;
         len = w;
      end else begin
         bits = (sample_bits_cfg == 0) ? 1 :
                ((sample_bits_cfg > 8) ? 8 : int'(sample_bits_cfg));
         planes = 1;
         len = (w * bits) / 8;
         if (len == 0) len = 1;
      end
   endfunction

   function automatic logic [7:0] clamp_to_byte(input int sum);
      if (sum < 0) return 8'd0;
      if (sum / FIXED_ONE > 255) return 8'd255;
      return 8'(sum / FIXED_ONE);
   endfunction

   // Step the predictor by one accepted byte; queue the pixel it releases
   task automatic predict_pixel(input logic [7:0] b);
      int planes, len, lines;
      int luma, cb, cr;
      logic [7:0] a0, a1, a2;
      pixel_type px;
      bit releases;
      line_geometry(planes, len, lines);
      px = '0;
      releases = 1'b1;
      if (planes == 1) begin
         px.s0 = b;
         px.count = 3'd1;
      end else if (plane_pos + 1 < planes) begin
         line_store[plane_pos * LINE_MAX + pixel_pos] = b;
         releases = 1'b0;
      end else begin
         a0 = line_store[pixel_pos];
         a1 = line_store[LINE_MAX + pixel_pos];
         a2 = line_store[2 * LINE_MAX + pixel_pos];
         if (planes == 4) begin
            px.s0 = a0; px.s1 = a1; px.s2 = a2; px.s3 = b;
            px.count = 3'd4;
         end else begin
            case (colour_mode_cfg)
               p2i_pkg::MODE_CIELAB: begin
                  px.s0 = a0; px.s1 = a1 ^ LAB_FLIP; px.s2 = b ^ LAB_FLIP;
               end
               p2i_pkg::MODE_YCC: begin
                  luma = int'(a0) * FIXED_ONE;
                  cb = int'(a1) - CHROMA_MID;
                  cr = int'(b) - CHROMA_MID;
                  px.s0 = clamp_to_byte(luma + cr * R_FROM_CR);
                  px.s1 = clamp_to_byte(luma + cb * G_FROM_CB + cr * G_FROM_CR);
                  px.s2 = clamp_to_byte(luma + cb * B_FROM_CB);
               end
               default: begin
                  px.s0 = a0; px.s1 = a1; px.s2 = b;
               end
            endcase
            px.count = 3'd3;
         end
      end
      px.eol = (plane_pos + 1 == planes) && (pixel_pos + 1 == len);
      px.eoi = px.eol && (line_pos + 1 == lines);
      // advance the stream position, wrapping at the end of the image
      pixel_pos++;
      if (pixel_pos >= len) begin
         pixel_pos = 0;
         plane_pos++;
         if (plane_pos >= planes) begin
            plane_pos = 0;
            line_pos++;
            if (line_pos >= lines) line_pos = 0;
         end
      end
      if (releases) expected_pixels.push_back(px);
   endtask

   // ---------------------------------------------------------------- drivers

   // Offer one byte, with random idle cycles in front of it
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      predict_pixel(value);
   endtask

   // Stop sending and wait until every predicted pixel has come out
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write on the idle stream; unused upper bits carry random junk
   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      logic [31:0] keep;
      settle();
      case (index)
         p2i_pkg::REG_PIXELS_PER_LINE: keep = 32'h3FFF;
         p2i_pkg::REG_LINES_PER_IMAGE: keep = 32'hFFFF;
         p2i_pkg::REG_CHANNEL_COUNT:   keep = 32'h7;
         p2i_pkg::REG_SAMPLE_BITS:     keep = 32'hF;
         p2i_pkg::REG_COLOR_MODE:      keep = 32'h3;
         default:                      keep = 32'h0;
      endcase
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= (value & keep) | ($urandom & ~keep);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         p2i_pkg::REG_PIXELS_PER_LINE: pixels_cfg      = value[13:0];
         p2i_pkg::REG_LINES_PER_IMAGE: lines_cfg       = value[15:0];
         p2i_pkg::REG_CHANNEL_COUNT:   channels_cfg    = value[2:0];
         p2i_pkg::REG_SAMPLE_BITS:     sample_bits_cfg = value[3:0];
         p2i_pkg::REG_COLOR_MODE:      colour_mode_cfg = value[1:0];
         default: ;
      endcase
      plane_pos = 0;
      pixel_pos = 0;
      line_pos  = 0;
      writes_done++;
   endtask

   task automatic write_image_shape(input int pixels, input int lines, input int chans,
                                    input int bits, input logic [1:0] mode);
      csr_write(p2i_pkg::REG_PIXELS_PER_LINE, pixels);
      csr_write(p2i_pkg::REG_LINES_PER_IMAGE, lines);
      csr_write(p2i_pkg::REG_CHANNEL_COUNT, chans);
      csr_write(p2i_pkg::REG_SAMPLE_BITS, bits);
      csr_write(p2i_pkg::REG_COLOR_MODE, mode);
   endtask

   // ---------------------------------------------------------------- tests

   // Register defaults: one-pixel, one-line, three-channel copy
   task automatic test_reset_defaults();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h5A);
   endtask

   // CIELAB chroma flip with zero width and zero lines; then the spare mode
   task automatic test_cielab_and_spare_mode();
      write_image_shape(0, 0, 3, 8, p2i_pkg::MODE_CIELAB);
      send_byte(8'h00);
      send_byte(8'h7F);
      send_byte(8'hFF);
      csr_write(p2i_pkg::REG_COLOR_MODE, 2'd3);
      send_byte(8'hA5);
      send_byte(8'h01);
      send_byte(8'h80);
   endtask

   // YCbCr to RGB with both clamps
   task automatic test_ycc_clamping();
      write_image_shape(1, 1, 3, 8, p2i_pkg::MODE_YCC);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
   endtask

   // Four channels ignore the colour mode
   task automatic test_four_channels();
      write_image_shape(1, 1, 4, 8, p2i_pkg::MODE_YCC);
      send_byte(8'h12);
      send_byte(8'h34);
      send_byte(8'h56);
      send_byte(8'h78);
   endtask

   // Passthrough: rounded-down line length raised to one, bits saturated, image wrap
   task automatic test_passthrough_lengths();
      write_image_shape(3, 1, 1, 0, p2i_pkg::MODE_COPY);
      send_byte(8'hC3);
      send_byte(8'h3C);
      write_image_shape(2, 2, 7, 15, p2i_pkg::MODE_CIELAB);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'h04);
      send_byte(8'h08);
   endtask

   // A write to an unmapped index mid-line restarts at the first byte
   task automatic test_restart_on_write();
      write_image_shape(2, 1, 3, 8, p2i_pkg::MODE_COPY);
      send_byte(8'hEE);
      csr_write(REG_UNMAPPED, 32'h0);
      send_byte(8'h10);
      send_byte(8'h20);
      send_byte(8'h30);
      send_byte(8'h40);
      send_byte(8'h50);
      send_byte(8'h60);
   endtask

   // Largest register values, each run cut short well before the line end
   task automatic test_widest_lines();
      write_image_shape(16383, 1, 4, 0, p2i_pkg::MODE_YCC);
      repeat (12) send_byte(8'($urandom_range(0, 255)));
      write_image_shape(LINE_MAX, 65535, 2, 1, p2i_pkg::MODE_COPY);
      repeat (12) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic write_random_settings();
      int chans, pixels, pick;
      pick = $urandom_range(0, 9);
      chans = (pick < 5) ? 3 : ((pick < 7) ? 4 : $urandom_range(0, 7));
      pick = $urandom_range(0, 19);
      pixels = (pick == 0) ? 0 : ((pick < 17) ? $urandom_range(1, 6) : $urandom_range(7, 40));
      pick = $urandom_range(0, 9);
      write_image_shape(pixels, $urandom_range(0, 3), chans, $urandom_range(0, 15),
                        (pick < 4) ? p2i_pkg::MODE_YCC : 2'($urandom_range(0, 3)));
   endtask

   // Random settings, mostly whole images of random bytes, some cut short
   task automatic test_random_images(input int budget);
      int sent, planes, len, lines, burst, i;
      sent = 0;
      while (sent < budget) begin
         write_random_settings();
         line_geometry(planes, len, lines);
         burst = planes * len * lines * $urandom_range(1, 2);
         if ($urandom_range(0, 9) < 3) burst = $urandom_range(1, burst);
         if (burst > budget - sent) burst = budget - sent;
         for (i = 0; i < burst; i++) begin
            send_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 99) == 0) settle();
         end
         sent += burst;
      end
      settle();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      predictor_reset();
      sender_idle_pct   = 34;
      receiver_idle_pct = 79;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_cielab_and_spare_mode();
      test_ycc_clamping();
      test_four_channels();
      test_passthrough_lengths();
      test_restart_on_write();
      test_random_images(200);

      sender_idle_pct   = 79;
      receiver_idle_pct = 34;
      test_random_images(200);

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_widest_lines();
      test_random_images(196);

      settle();
      $display("Sent %0d planar bytes, checked %0d pixels across %0d register writes",
               bytes_sent, pixels_checked, writes_done);
      $display("Modes: copy, CIELAB, YCbCr, spare, four-channel, passthrough; %0d errors",
               fail_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
